// ===== hw/rtl/tfn_pkg.sv =====
// shared types, constants and functions for the triangle face normal unit
`timescale 1ns / 1ps
package tfn_pkg;
  localparam int CoordW = 24;
  localparam int NormW  = 16;
  localparam int CrossW = 51;
  localparam int MagW   = 50;
  localparam int NormW_ = 30;
  localparam int SqW    = 62;
  localparam int RootW  = 31;
  localparam int QuotW  = 15;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic signed [CoordW-1:0] first_x, first_y, first_z;
    logic signed [CoordW-1:0] second_x, second_y, second_z;
    logic signed [CoordW-1:0] third_x, third_y, third_z;
  } tri_t;

  typedef struct packed {
    logic signed [NormW-1:0] norm_x, norm_y, norm_z;
    logic degenerate;
  } norm_t;

  // front result: largest magnitude scaled into [2^29, 2^30), signs, degenerate
  typedef struct packed {
    logic [2:0][NormW_-1:0] mag;
    logic [2:0]             neg;
    logic                   degenerate;
  } job_t;

  function automatic logic [5:0] bit_len(input logic [MagW-1:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < MagW; i++)
      if (v[i]) n = 6'(i + 1);
    return n;
  endfunction
endpackage

// ===== hw/rtl/tfn_if.sv =====
// valid/ready channel with a generic payload
`timescale 1ns / 1ps
interface tfn_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tfn_front.sv =====
// front: edges, cross product, magnitude scaling, as registered stages
`timescale 1ns / 1ps
module tfn_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  tfn_pkg::tri_t  in_data,
  output logic           out_valid,
  output tfn_pkg::job_t  out_data
);
  import tfn_pkg::*;
  logic [3:0] vld;
  logic signed [CoordW:0] e1 [3], e2 [3];
  logic signed [2*CoordW+1:0] pr [6];
  logic signed [CrossW-1:0] cr [3];
  logic [MagW-1:0] mg [3];
  logic [2:0] ng;
  logic [5:0] bl;
  job_t job;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1[0] <= (CoordW+1)'(in_data.second_x) - (CoordW+1)'(in_data.first_x);
      e1[1] <= (CoordW+1)'(in_data.second_y) - (CoordW+1)'(in_data.first_y);
      e1[2] <= (CoordW+1)'(in_data.second_z) - (CoordW+1)'(in_data.first_z);
      e2[0] <= (CoordW+1)'(in_data.third_x) - (CoordW+1)'(in_data.first_x);
      e2[1] <= (CoordW+1)'(in_data.third_y) - (CoordW+1)'(in_data.first_y);
      e2[2] <= (CoordW+1)'(in_data.third_z) - (CoordW+1)'(in_data.first_z);
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++)
        cr[i] <= CrossW'(pr[2*i]) - CrossW'(pr[2*i+1]);
      for (int i = 0; i < 3; i++) begin
        ng[i] <= cr[i][CrossW-1];
        mg[i] <= cr[i][CrossW-1] ? MagW'(-cr[i]) : MagW'(cr[i]);
      end
      out_data <= job;
    end
  end

  always_comb begin
    bl = bit_len(mg[0] | mg[1] | mg[2]);
    job.neg = ng;
    job.degenerate = (bl == 6'd0);
    for (int i = 0; i < 3; i++) begin
      if (bl > 6'd30) job.mag[i] = NormW_'(mg[i] >> (bl - 6'd30));
      else job.mag[i] = NormW_'(mg[i] << (6'd30 - bl));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[3];
  end
endmodule

// ===== hw/rtl/tfn_queue.sv =====
// small fifo between front and back
`timescale 1ns / 1ps
module tfn_queue #(
  parameter int Depth = tfn_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tfn_pkg::job_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output tfn_pkg::job_t pop_data,
  output logic [$clog2(Depth+1)-1:0] count
);
  import tfn_pkg::*;
  localparam int AW = $clog2(Depth);
  job_t mem [Depth];
  logic [AW-1:0] wp, rp;

  assign not_empty = count != '0;
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end
endmodule

// ===== hw/rtl/tfn_back.sv =====
// back: sum of squares, pipelined square root, pipelined dividers, rounding
`timescale 1ns / 1ps
module tfn_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  tfn_pkg::job_t in_data,
  output logic          out_valid,
  output tfn_pkg::norm_t out_data
);
  import tfn_pkg::*;
  localparam int RootSteps = RootW;
  localparam int DivSteps  = QuotW;
  localparam int NumW      = NormW_ + 15;
  localparam int Lat = 3 + RootSteps + DivSteps;

  logic [Lat-1:0] vld;
  job_t job_s [Lat];
  logic [2*NormW_-1:0] sq [3];
  logic [SqW-1:0] sum;
  // square root pipeline, one result bit per stage
  logic [SqW+1:0] rem [RootSteps+1];
  logic [RootW-1:0] root [RootSteps+1];
  logic [SqW-1:0] rad [RootSteps+1];
  // divide pipeline, one quotient bit per stage, per lane
  logic [NumW-1:0] num [DivSteps+1][3];
  logic [RootW:0] drem [DivSteps+1][3];
  logic [QuotW-1:0] quo [DivSteps+1][3];
  logic [RootW-1:0] len [DivSteps+1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_s[0] <= in_data;
      for (int k = 1; k < Lat; k++) job_s[k] <= job_s[k-1];
      for (int i = 0; i < 3; i++) sq[i] <= in_data.mag[i] * in_data.mag[i];
      rad[0] <= SqW'(sq[0]) + SqW'(sq[1]) + SqW'(sq[2]);
      rem[0] <= '0;
      root[0] <= '0;
      for (int k = 0; k < RootSteps; k++) begin
        logic [SqW+1:0] r2, t;
        r2 = {rem[k][SqW-1:0], rad[k][SqW-1 -: 2]};
        t = {root[k], 2'b01};
        if (r2 >= t) begin
          rem[k+1] <= r2 - t;
          root[k+1] <= {root[k][RootW-2:0], 1'b1};
        end else begin
          rem[k+1] <= r2;
          root[k+1] <= {root[k][RootW-2:0], 1'b0};
        end
        rad[k+1] <= rad[k] << 2;
      end
      len[0] <= root[RootSteps];
      for (int i = 0; i < 3; i++) begin
        num[0][i] <= {job_s[RootSteps+1].mag[i], 14'd0} + NumW'(root[RootSteps] >> 1);
        drem[0][i] <= '0;
        quo[0][i] <= '0;
      end
      for (int k = 0; k < DivSteps; k++) begin
        len[k+1] <= len[k];
        for (int i = 0; i < 3; i++) begin
          logic [RootW+1:0] d2;
          logic [NumW-1:0] nn;
          nn = num[k][i];
          // first step folds in the high numerator bits below the divisor range
          if (k == 0) begin
            d2 = {2'b00, nn[NumW-1 -: RootW]};
            nn = nn << RootW;
          end else begin
            d2 = {drem[k][i], nn[NumW-1]};
            nn = nn << 1;
          end
          if (d2 >= {1'b0, len[k]}) begin
            drem[k+1][i] <= (RootW+1)'(d2 - {1'b0, len[k]});
            quo[k+1][i] <= {quo[k][i][QuotW-2:0], 1'b1};
          end else begin
            drem[k+1][i] <= (RootW+1)'(d2);
            quo[k+1][i] <= {quo[k][i][QuotW-2:0], 1'b0};
          end
          num[k+1][i] <= nn;
        end
      end
    end
  end

  always_comb begin
    job_t j;
    logic [NormW-1:0] q;
    j = job_s[Lat-1];
    out_data.degenerate = j.degenerate;
    out_data.norm_x = '0;
    out_data.norm_y = '0;
    out_data.norm_z = '0;
    for (int i = 0; i < 3; i++) begin
      q = {1'b0, quo[DivSteps][i]};
      if (q > 16'd16384) q = 16'd16384;
      if (j.neg[i]) q = -q;
      if (j.degenerate) q = '0;
      case (i)
        0: out_data.norm_x = q;
        1: out_data.norm_y = q;
        default: out_data.norm_z = q;
      endcase
    end
  end

  assign out_valid = vld[Lat-1];
endmodule

// ===== hw/rtl/triangle_face_normal_unit.sv =====
// top level of the triangle face normal unit
`timescale 1ns / 1ps
// Usage:
//   tri_in  : sink channel, one transaction carries the three vertices of one
//             triangle (24-bit signed, 8 fraction bits)
//   norm_out: source channel, one transaction per triangle, unit normal in
//             signed Q1.14 plus a degenerate flag for a zero cross product
// Throughput: one triangle per cycle while the receiver keeps ready high.
// Path: the front (edges, products, cross, magnitude, scaling), the queue,
//   the back (squares, sum, the 31-stage square root pipeline, the 15-stage
//   divide pipeline) and the output register.
// The front and back are separate pipelines joined by a small queue; the
// back advances only when its output register can move or its last stage is
// empty, the front only when the queue has room for everything the front holds.
// Reset (rst, synchronous) empties the pipelines, the queue and the output
// register. A stalled receiver keeps the result held; input ready drops
// once the queue could fill.
module triangle_face_normal_unit #(
  parameter int QueueDepth = tfn_pkg::QueueDepth + 4
) (
  input  logic clk,
  input  logic rst,
  tfn_if.sink   tri_in,
  tfn_if.source norm_out
);
  import tfn_pkg::*;
  localparam int CW = $clog2(QueueDepth+1);

  logic f_en, f_valid;
  job_t f_data;
  logic q_ne, q_pop;
  job_t q_data;
  logic [CW-1:0] q_cnt;
  logic b_en, b_valid;
  norm_t b_data;
  logic o_valid;
  norm_t o_data;

  // front holds up to 5 items in flight; only advance with room for them
  assign f_en = q_cnt <= CW'(QueueDepth - 5);
  assign tri_in.ready = f_en;

  tfn_front u_front (
    .clk(clk), .rst(rst), .en(f_en),
    .in_valid(tri_in.valid && f_en), .in_data(tri_in.data),
    .out_valid(f_valid), .out_data(f_data)
  );

  // back advances whenever its tail item can land in the output register
  assign b_en = !o_valid || norm_out.ready || !b_valid;
  assign q_pop = b_en && q_ne;

  tfn_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .push(f_valid && f_en), .push_data(f_data),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_data), .count(q_cnt)
  );

  tfn_back u_back (
    .clk(clk), .rst(rst), .en(b_en),
    .in_valid(q_pop), .in_data(q_data),
    .out_valid(b_valid), .out_data(b_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (!o_valid || norm_out.ready) o_valid <= b_valid && b_en;
  end

  always_ff @(posedge clk) begin
    if ((!o_valid || norm_out.ready) && b_valid && b_en) o_data <= b_data;
  end

  assign norm_out.valid = o_valid;
  assign norm_out.data = o_data;

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= CW'(QueueDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_ne) else $error("pop from empty queue");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_data.degenerate |-> o_data.norm_x == '0 && o_data.norm_y == '0
    && o_data.norm_z == '0) else $error("degenerate with nonzero normal");
endmodule

// ===== verif/tfn_scoreboard.sv =====
// scoreboard class that predicts the unit face normal and checks results
`timescale 1ns / 1ps
class tfn_scoreboard;
  tfn_pkg::norm_t pending_normals[$];
  int mismatches;
  int checked;
  int degenerate_seen;
  int saturated_seen;

  function new();
    mismatches = 0;
    checked = 0;
    degenerate_seen = 0;
    saturated_seen = 0;
  endfunction

  // floor square root of a value below 2^62
  static function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function automatic tfn_pkg::norm_t face_normal(input tfn_pkg::tri_t t);
    tfn_pkg::norm_t res;
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
    logic signed [63:0] cr [3];
    logic [63:0] a [3];
    logic [63:0] m, s, len, q;
    int bl;
    e1[0] = 64'(t.second_x) - 64'(t.first_x);
    e1[1] = 64'(t.second_y) - 64'(t.first_y);
    e1[2] = 64'(t.second_z) - 64'(t.first_z);
    e2[0] = 64'(t.third_x) - 64'(t.first_x);
    e2[1] = 64'(t.third_y) - 64'(t.first_y);
    e2[2] = 64'(t.third_z) - 64'(t.first_z);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
      if (a[i] > m) m = a[i];
    end
    res = '0;
    if (m == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    bl = 0;
    for (int i = 0; i < 64; i++) if (m[i]) bl = i + 1;
    for (int i = 0; i < 3; i++)
      a[i] = (bl > 30) ? a[i] >> (bl - 30) : a[i] << (30 - bl);
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    len = floor_root(s);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] * 64'd16384 + (len >> 1)) / len;
      if (q > 64'd16384) q = 64'd16384;
      if (cr[i] < 0) q = -q;
      if (i == 0) res.norm_x = q[15:0];
      else if (i == 1) res.norm_y = q[15:0];
      else res.norm_z = q[15:0];
    end
    return res;
  endfunction

  function void note_triangle(input tfn_pkg::tri_t t);
    pending_normals.push_back(face_normal(t));
  endfunction

  function void check_normal(input tfn_pkg::norm_t got);
    tfn_pkg::norm_t want;
    if (pending_normals.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected normal %p", got);
      return;
    end
    want = pending_normals.pop_front();
    checked++;
    if (want.degenerate) degenerate_seen++;
    if (want.norm_x == 16384 || want.norm_x == -16384 || want.norm_y == 16384 ||
        want.norm_y == -16384 || want.norm_z == 16384 || want.norm_z == -16384)
      saturated_seen++;
    if (got.norm_x !== want.norm_x || got.norm_y !== want.norm_y ||
        got.norm_z !== want.norm_z || got.degenerate !== want.degenerate) begin
      mismatches++;
      if (mismatches <= 10)
        $display("normal mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                 want.norm_x, want.norm_y, want.norm_z, want.degenerate,
                 got.norm_x, got.norm_y, got.norm_z, got.degenerate);
    end
  endfunction
endclass

// ===== verif/tb_triangle_face_normal_unit.sv =====
// testbench top for the triangle face normal unit
`timescale 1ns / 1ps
module tb_triangle_face_normal_unit;
  import tfn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfn_if #(.payload_t(tri_t))  tri_ch  (clk);
  tfn_if #(.payload_t(norm_t)) norm_ch (clk);

  triangle_face_normal_unit dut (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_ch.sink),
    .norm_out(norm_ch.source)
  );

  tfn_scoreboard normals = new();
  int sent = 0;
  bit stim_done = 0;

  always #4 clk = ~clk;

  // gap length: mostly zero or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord(input int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic tri_t rand_triangle();
    tri_t t;
    int mode;
    mode = $urandom_range(0, 3);
    t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode),
         rand_coord(mode), rand_coord(mode), rand_coord(mode)};
    // sometimes share a coordinate or merge two vertices so degenerate cases appear
    case ($urandom_range(0, 19))
      0: t.third_x = t.first_x;
      1: begin
        t.second_x = t.first_x; t.second_y = t.first_y; t.second_z = t.first_z;
      end
      2: begin
        t.third_x = t.second_x; t.third_y = t.second_y; t.third_z = t.second_z;
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic tri_t make_tri(input logic [CoordW-1:0] a, b, c, d, e, f, g, h, i);
    return {a, b, c, d, e, f, g, h, i};
  endfunction

  // send one triangle after an optional idle gap; data changes on the falling edge
  task automatic send_triangle(input tri_t t, input bit with_gaps);
    int g;
    g = with_gaps ? gap_len() : 0;
    if (g > 0) begin
      tri_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    tri_ch.valid <= 1'b1;
    tri_ch.data  <= t;
    @(posedge clk);
    while (!tri_ch.ready) @(posedge clk);
    normals.note_triangle(t);
    sent++;
    @(negedge clk);
  endtask

  // receiver: ready toggles randomly, with a calm stretch in the middle
  initial begin
    int g;
    norm_ch.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      g = (sent > 300 && sent < 400) ? 0 : gap_len();
      if (g > 0) begin
        norm_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      norm_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // result transactions are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && norm_ch.valid && norm_ch.ready) normals.check_normal(norm_ch.data);
  end

  initial begin
    tri_t t;
    tri_ch.valid = 1'b0;
    tri_ch.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: point triangle, axis-aligned faces, extremes, saturation candidates
    send_triangle('0, 0);
    send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
    send_triangle(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0), 0);
    send_triangle(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256), 0);
    send_triangle(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0), 0);
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 0);
    send_triangle(make_tri(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
                           24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000), 0);
    send_triangle(make_tri(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                           24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF), 0);
    send_triangle(make_tri(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                           24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF), 0);
    send_triangle(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2), 0);
    send_triangle(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 3), 0);
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 1), 0);
    send_triangle(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 1), 0);
    send_triangle(make_tri(0, 0, 0, 24'hFFFFFF, 0, 0, 0, 24'hFFFFFF, 0), 0);
    send_triangle(make_tri(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555,
                           24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA), 0);

    for (int n = 0; n < 650; n++) begin
      // hold off once until the pipeline has drained completely
      if (n == 200) begin
        tri_ch.valid <= 1'b0;
        while (normals.pending_normals.size() != 0) @(negedge clk);
      end
      t = rand_triangle();
      send_triangle(t, (n < 300 || n >= 400));
    end
    tri_ch.valid <= 1'b0;

    while (normals.pending_normals.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("covered %0d triangles, %0d normals checked", sent, normals.checked);
    $display("degenerate cases %0d, full-scale components %0d, mismatches %0d",
             normals.degenerate_seen, normals.saturated_seen, normals.mismatches);
    if (normals.mismatches == 0 && normals.pending_normals.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_if.sv
hw/rtl/tfn_front.sv
hw/rtl/tfn_queue.sv
hw/rtl/tfn_back.sv
hw/rtl/triangle_face_normal_unit.sv
verif/tfn_scoreboard.sv
verif/tb_triangle_face_normal_unit.sv
